// ===== src/dltq_pkg.sv =====
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared constants, codes and controller/datapath interface types for the
// delta-list timer queues.
// ----------------------------------------------------------------------------
package dltq_pkg;

    localparam int DEF_MAX_QUEUES      = 8;
    localparam int DEF_SLOTS_PER_QUEUE = 8;
    localparam int DEF_EVENT_COUNT     = 64;

    localparam int QIU_W     = 4;
    localparam int QIU_RESET = 5;
    localparam int TIME_W    = 32;
    localparam int EVT_W     = 6;
    localparam int FUNC_W    = 2;
    localparam int KIND_W    = 3;
    localparam int ENTRY_W   = EVT_W + TIME_W + 2;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 40;

    // operations
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_EXPIRE = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ADDED   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ARMED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FULL    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NEXT    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NONE    = 3'd5;

    // controller states, also the datapath operation code
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [ST_W-1:0] ST_DECODE   = 4'd1;
    localparam logic [ST_W-1:0] ST_ADD_RD   = 4'd2;
    localparam logic [ST_W-1:0] ST_ADD_CHK  = 4'd3;
    localparam logic [ST_W-1:0] ST_SH_RD    = 4'd4;
    localparam logic [ST_W-1:0] ST_SH_WR    = 4'd5;
    localparam logic [ST_W-1:0] ST_INS      = 4'd6;
    localparam logic [ST_W-1:0] ST_FIND_RD  = 4'd7;
    localparam logic [ST_W-1:0] ST_FIND_CHK = 4'd8;
    localparam logic [ST_W-1:0] ST_EXP_Q    = 4'd9;
    localparam logic [ST_W-1:0] ST_EXP_CHK  = 4'd10;
    localparam logic [ST_W-1:0] ST_EXP_SH   = 4'd11;
    localparam logic [ST_W-1:0] ST_EXP_SHW  = 4'd12;
    localparam logic [ST_W-1:0] ST_EXP_DEC  = 4'd13;
    localparam logic [ST_W-1:0] ST_EMIT     = 4'd14;

    typedef struct packed {
        logic [ST_W-1:0]   op;
        logic              load;
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic              last;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              armed_hit;
        logic              full;
        logic              fill_zero;
        logic              walk_go;
        logic              walk_more;
        logic              idx_gt_pos;
        logic              idx_lt_fill;
        logic              q_end;
        logic              exp_pop;
        logic              have_held;
        logic              out_free;
    } status_t;

endpackage

// ===== src/dltq_ram.sv =====
// ----------------------------------------------------------------------------
// dltq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dltq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dltq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dltq_ctrl
// Sequencer for add, find and expire; drives datapath commands.
// ----------------------------------------------------------------------------
module dltq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  dltq_pkg::status_t st,
    output dltq_pkg::cmd_t    cmd
);

    logic [dltq_pkg::ST_W-1:0]   state_reg, state_next;
    logic [dltq_pkg::KIND_W-1:0] kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dltq_pkg::ST_IDLE;
            kind_reg  <= dltq_pkg::KIND_ADDED;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign s_tready = (state_reg == dltq_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd.op     = state_reg;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.kind   = kind_reg;
        cmd.last   = 1'b1;
        unique case (state_reg)
            dltq_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = dltq_pkg::ST_DECODE;
                end
            end
            dltq_pkg::ST_DECODE:
            begin
                case (st.func)
                    dltq_pkg::FUNC_ADD:
                    begin
                        if (st.armed_hit)
                        begin
                            kind_next  = dltq_pkg::KIND_ARMED;
                            state_next = dltq_pkg::ST_EMIT;
                        end
                        else if (st.full)
                        begin
                            kind_next  = dltq_pkg::KIND_FULL;
                            state_next = dltq_pkg::ST_EMIT;
                        end
                        else if (st.fill_zero)
                        begin
                            state_next = dltq_pkg::ST_INS;
                        end
                        else
                        begin
                            state_next = dltq_pkg::ST_ADD_RD;
                        end
                    end
                    dltq_pkg::FUNC_FIND:   state_next = dltq_pkg::ST_FIND_RD;
                    dltq_pkg::FUNC_EXPIRE: state_next = dltq_pkg::ST_EXP_Q;
                    default:               state_next = dltq_pkg::ST_IDLE;
                endcase
            end
            dltq_pkg::ST_ADD_RD:  state_next = dltq_pkg::ST_ADD_CHK;
            dltq_pkg::ST_ADD_CHK:
            begin
                if (st.walk_go && st.walk_more)
                begin
                    state_next = dltq_pkg::ST_ADD_RD;
                end
                else
                begin
                    state_next = dltq_pkg::ST_SH_RD;
                end
            end
            dltq_pkg::ST_SH_RD:
            begin
                state_next = st.idx_gt_pos ? dltq_pkg::ST_SH_WR : dltq_pkg::ST_INS;
            end
            dltq_pkg::ST_SH_WR:   state_next = dltq_pkg::ST_SH_RD;
            dltq_pkg::ST_INS:
            begin
                kind_next  = dltq_pkg::KIND_ADDED;
                state_next = dltq_pkg::ST_EMIT;
            end
            dltq_pkg::ST_FIND_RD:
            begin
                if (st.q_end)
                begin
                    kind_next  = dltq_pkg::KIND_NEXT;
                    state_next = dltq_pkg::ST_EMIT;
                end
                else if (!st.fill_zero)
                begin
                    state_next = dltq_pkg::ST_FIND_CHK;
                end
            end
            dltq_pkg::ST_FIND_CHK: state_next = dltq_pkg::ST_FIND_RD;
            dltq_pkg::ST_EXP_Q:
            begin
                if (st.q_end)
                begin
                    kind_next  = st.have_held ? dltq_pkg::KIND_EXPIRED
                                              : dltq_pkg::KIND_NONE;
                    state_next = dltq_pkg::ST_EMIT;
                end
                else if (!st.fill_zero)
                begin
                    state_next = dltq_pkg::ST_EXP_CHK;
                end
            end
            dltq_pkg::ST_EXP_CHK:
            begin
                if (!st.exp_pop)
                begin
                    state_next = dltq_pkg::ST_EXP_Q;
                end
                else if (!st.have_held || st.out_free)
                begin
                    // previous pop goes out now, it is not the final one
                    cmd.emit   = st.have_held;
                    cmd.kind   = dltq_pkg::KIND_EXPIRED;
                    cmd.last   = 1'b0;
                    state_next = dltq_pkg::ST_EXP_SH;
                end
            end
            dltq_pkg::ST_EXP_SH:
            begin
                state_next = st.idx_lt_fill ? dltq_pkg::ST_EXP_SHW : dltq_pkg::ST_EXP_DEC;
            end
            dltq_pkg::ST_EXP_SHW: state_next = dltq_pkg::ST_EXP_SH;
            dltq_pkg::ST_EXP_DEC: state_next = dltq_pkg::ST_EXP_Q;
            dltq_pkg::ST_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = dltq_pkg::ST_IDLE;
                end
            end
            default: state_next = dltq_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== src/dltq_dp.sv =====
// ----------------------------------------------------------------------------
// dltq_dp
// Datapath: item registers, queue fill counts, armed map, slot RAM access,
// walk and expire arithmetic, output register.
// ----------------------------------------------------------------------------
module dltq_dp #(
    parameter int MAX_QUEUES      = dltq_pkg::DEF_MAX_QUEUES,
    parameter int SLOTS_PER_QUEUE = dltq_pkg::DEF_SLOTS_PER_QUEUE,
    parameter int EVENT_COUNT     = dltq_pkg::DEF_EVENT_COUNT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [dltq_pkg::QIU_W-1:0]    cfg_wr_data,
    input  logic [dltq_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [dltq_pkg::FUNC_W-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dltq_pkg::M_DATA_W-1:0] m_tdata,
    output logic [dltq_pkg::KIND_W-1:0]   m_tuser,
    output logic                          m_tlast,
    input  dltq_pkg::cmd_t                cmd,
    output dltq_pkg::status_t             st
);

    localparam int QW    = $clog2(MAX_QUEUES + 1);
    localparam int QIW   = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
    localparam int FW    = $clog2(SLOTS_PER_QUEUE + 1);
    localparam int DEPTH = MAX_QUEUES * SLOTS_PER_QUEUE;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = $clog2(EVENT_COUNT);
    localparam int TW    = dltq_pkg::TIME_W;
    localparam int VW    = dltq_pkg::EVT_W;

    function automatic logic [VW-1:0] ev_wrap(input logic [VW-1:0] e);
        logic [8:0] r;
        r = 9'(e);
        for (int i = 0; i < 8; i++)
        begin
            if (r >= 9'(EVENT_COUNT))
            begin
                r = r - 9'(EVENT_COUNT);
            end
        end
        return VW'(r);
    endfunction

    logic [dltq_pkg::QIU_W-1:0]  qiu_reg;
    logic [QIW-1:0]              cur_reg;
    logic [FW-1:0]               fill_reg [MAX_QUEUES];
    logic [EVENT_COUNT-1:0]      armed_reg;
    logic [dltq_pkg::FUNC_W-1:0] func_reg;
    logic [VW-1:0]               ev_reg;
    logic [TW-1:0]               time_reg;
    logic                        dly_reg, rdy_reg;
    logic [QW-1:0]               q_reg;
    logic [FW-1:0]               pos_reg, idx_reg;
    logic [TW-1:0]               t_reg, rem_reg, best_reg;
    logic                        any_reg;
    logic [VW-1:0]               held_ev_reg;
    logic                        held_fired_reg, held_tmo_reg, have_held_reg;
    logic                        out_valid_reg, out_fired_reg, out_tmo_reg, out_last_reg;
    logic [dltq_pkg::KIND_W-1:0] out_kind_reg;
    logic [VW-1:0]               out_ev_reg;
    logic [TW-1:0]               out_next_reg;

    logic [QW-1:0]                 nq, add_q, q_inc;
    logic [QIW-1:0]                qi;
    logic [FW-1:0]                 fill_q;
    logic                          re, we;
    logic [AW-1:0]                 raddr, waddr;
    logic [dltq_pkg::ENTRY_W-1:0]  wdata, rdata;
    logic [FW-1:0]                 rd_slot, wr_slot;
    logic [VW-1:0]                 rd_ev, in_ev;
    logic [TW-1:0]                 rd_delta, in_time;
    logic                          rd_dly, rd_rdy, out_free;

    assign in_ev   = s_tdata[VW-1:0];
    assign in_time = s_tdata[VW+TW-1:VW];

    always_comb
    begin
        if (qiu_reg == '0)
        begin
            nq = QW'(1);
        end
        else if (int'(qiu_reg) > MAX_QUEUES)
        begin
            nq = QW'(MAX_QUEUES);
        end
        else
        begin
            nq = QW'(qiu_reg);
        end
    end

    assign add_q  = (QW'(cur_reg) < nq) ? QW'(cur_reg) : '0;
    assign qi     = q_reg[QIW-1:0];
    assign fill_q = fill_reg[qi];
    assign q_inc  = q_reg + QW'(1);

    assign rd_ev    = rdata[VW-1:0];
    assign rd_delta = rdata[VW+TW-1:VW];
    assign rd_dly   = rdata[VW+TW];
    assign rd_rdy   = rdata[VW+TW+1];

    assign out_free = !out_valid_reg || m_tready;

    assign st.func        = func_reg;
    assign st.armed_hit   = armed_reg[EW'(ev_reg)];
    assign st.full        = (int'(fill_q) >= SLOTS_PER_QUEUE);
    assign st.fill_zero   = (fill_q == '0);
    assign st.walk_go     = (t_reg > rd_delta);
    assign st.walk_more   = ((FW + 1)'(pos_reg) + (FW + 1)'(1)) < (FW + 1)'(fill_q);
    assign st.idx_gt_pos  = (idx_reg > pos_reg);
    assign st.idx_lt_fill = (idx_reg < fill_q);
    assign st.q_end       = (q_reg >= nq);
    assign st.exp_pop     = (rd_delta <= rem_reg);
    assign st.have_held   = have_held_reg;
    assign st.out_free    = out_free;

    // slot RAM port control
    always_comb
    begin
        re      = 1'b0;
        we      = 1'b0;
        rd_slot = '0;
        wr_slot = '0;
        wdata   = rdata;
        case (cmd.op)
            dltq_pkg::ST_ADD_RD:
            begin
                re      = 1'b1;
                rd_slot = pos_reg;
            end
            dltq_pkg::ST_SH_RD:
            begin
                re      = st.idx_gt_pos;
                rd_slot = idx_reg - FW'(1);
            end
            dltq_pkg::ST_SH_WR:
            begin
                we      = 1'b1;
                wr_slot = idx_reg;
                // the entry moving off the insert point is the successor
                if (idx_reg - FW'(1) == pos_reg)
                begin
                    wdata = {rd_rdy, rd_dly, rd_delta - t_reg, rd_ev};
                end
            end
            dltq_pkg::ST_INS:
            begin
                we      = 1'b1;
                wr_slot = pos_reg;
                wdata   = {rdy_reg, dly_reg, t_reg, ev_reg};
            end
            dltq_pkg::ST_FIND_RD, dltq_pkg::ST_EXP_Q:
            begin
                re = !st.q_end && !st.fill_zero;
            end
            dltq_pkg::ST_EXP_CHK:
            begin
                we    = !st.exp_pop;
                wdata = {rd_rdy, rd_dly, rd_delta - rem_reg, rd_ev};
            end
            dltq_pkg::ST_EXP_SH:
            begin
                re      = st.idx_lt_fill;
                rd_slot = idx_reg;
            end
            dltq_pkg::ST_EXP_SHW:
            begin
                we      = 1'b1;
                wr_slot = idx_reg - FW'(1);
            end
            default:
            begin
                re = 1'b0;
            end
        endcase
    end

    assign raddr = AW'(AW'(qi) * SLOTS_PER_QUEUE) + AW'(rd_slot);
    assign waddr = AW'(AW'(qi) * SLOTS_PER_QUEUE) + AW'(wr_slot);

    dltq_ram #(
        .WIDTH (dltq_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qiu_reg       <= dltq_pkg::QIU_W'(dltq_pkg::QIU_RESET);
            cur_reg       <= '0;
            armed_reg     <= '0;
            have_held_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_QUEUES; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                qiu_reg <= cfg_wr_data;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                dltq_pkg::ST_INS:
                begin
                    fill_reg[qi]              <= fill_q + FW'(1);
                    armed_reg[EW'(ev_reg)]    <= 1'b1;
                    cur_reg <= (q_inc >= nq) ? '0 : QIW'(q_inc);
                end
                dltq_pkg::ST_EXP_CHK:
                begin
                    if (st.exp_pop && (!have_held_reg || out_free))
                    begin
                        have_held_reg          <= 1'b1;
                        armed_reg[EW'(rd_ev)]  <= 1'b0;
                    end
                end
                dltq_pkg::ST_EXP_DEC:
                begin
                    fill_reg[qi] <= fill_q - FW'(1);
                end
                default:
                begin
                    have_held_reg <= have_held_reg & ~cmd.load;
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= s_tuser;
            ev_reg   <= ev_wrap(in_ev);
            time_reg <= in_time;
            dly_reg  <= s_tdata[VW+TW];
            rdy_reg  <= s_tdata[VW+TW+1];
            q_reg    <= (s_tuser == dltq_pkg::FUNC_ADD) ? add_q : '0;
            pos_reg  <= '0;
            t_reg    <= in_time;
            rem_reg  <= in_time;
            any_reg  <= 1'b0;
            best_reg <= '0;
        end
        case (cmd.op)
            dltq_pkg::ST_DECODE:
            begin
                idx_reg <= fill_q;
            end
            dltq_pkg::ST_ADD_CHK:
            begin
                idx_reg <= fill_q;
                if (st.walk_go)
                begin
                    t_reg   <= t_reg - rd_delta;
                    pos_reg <= pos_reg + FW'(1);
                end
            end
            dltq_pkg::ST_SH_WR:
            begin
                idx_reg <= idx_reg - FW'(1);
            end
            dltq_pkg::ST_FIND_RD:
            begin
                if (!st.q_end && st.fill_zero)
                begin
                    q_reg <= q_inc;
                end
            end
            dltq_pkg::ST_FIND_CHK:
            begin
                if (!any_reg || rd_delta < best_reg)
                begin
                    best_reg <= rd_delta;
                end
                any_reg <= 1'b1;
                q_reg   <= q_inc;
            end
            dltq_pkg::ST_EXP_Q:
            begin
                if (!st.q_end && st.fill_zero)
                begin
                    q_reg   <= q_inc;
                    rem_reg <= time_reg;
                end
            end
            dltq_pkg::ST_EXP_CHK:
            begin
                if (!st.exp_pop)
                begin
                    q_reg   <= q_inc;
                    rem_reg <= time_reg;
                end
                else if (!have_held_reg || out_free)
                begin
                    rem_reg        <= rem_reg - rd_delta;
                    held_ev_reg    <= rd_ev;
                    held_fired_reg <= rd_dly ? rd_rdy : 1'b1;
                    held_tmo_reg   <= !rd_dly;
                    idx_reg        <= FW'(1);
                end
            end
            dltq_pkg::ST_EXP_SHW:
            begin
                idx_reg <= idx_reg + FW'(1);
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
        if (cmd.emit)
        begin
            out_kind_reg <= cmd.kind;
            out_last_reg <= cmd.last;
            if (cmd.kind == dltq_pkg::KIND_EXPIRED)
            begin
                out_ev_reg    <= held_ev_reg;
                out_fired_reg <= held_fired_reg;
                out_tmo_reg   <= held_tmo_reg;
            end
            else
            begin
                out_ev_reg    <= '0;
                out_fired_reg <= 1'b0;
                out_tmo_reg   <= 1'b0;
            end
            out_next_reg <= (cmd.kind == dltq_pkg::KIND_NEXT) ? best_reg : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_next_reg, out_tmo_reg, out_fired_reg, out_ev_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== src/delta_list_timer_queues_top.sv =====
// ----------------------------------------------------------------------------
// delta_list_timer_queues_top
// Round-robin set of sorted delta-list timer queues with add, find, expire.
// ----------------------------------------------------------------------------
// One beat is taken at a time. All slots live in one RAM with a single read
// port and a registered read, and that port sets the timing: add walks the
// queue slot by slot to the insert point, then shifts the later slots up one
// by one; find reads the head of each non-empty queue in use and skips empty
// queues; expire visits each queue, pops entries from its head and shifts the
// rest down after each pop. Output stalls hold all three.
// Results leave through an output register, so a new beat is taken while the
// last result still waits on m_tready.
// ----------------------------------------------------------------------------
module delta_list_timer_queues_top #(
    parameter int MAX_QUEUES      = dltq_pkg::DEF_MAX_QUEUES,
    parameter int SLOTS_PER_QUEUE = dltq_pkg::DEF_SLOTS_PER_QUEUE,
    parameter int EVENT_COUNT     = dltq_pkg::DEF_EVENT_COUNT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [dltq_pkg::QIU_W-1:0]    cfg_wr_data,  // queues_in_use
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // event_id[5:0], time_value[37:6], delayed_flag[38], ready_flag[39]
    input  logic [dltq_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [dltq_pkg::FUNC_W-1:0]   s_tuser,      // func[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_event[5:0], fired[6], timed_out[7], next_timeout[39:8]
    output logic [dltq_pkg::M_DATA_W-1:0] m_tdata,
    output logic [dltq_pkg::KIND_W-1:0]   m_tuser,      // kind[2:0]
    output logic                          m_tlast
);

    dltq_pkg::cmd_t    cmd;
    dltq_pkg::status_t st;

    dltq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    dltq_dp #(
        .MAX_QUEUES      (MAX_QUEUES),
        .SLOTS_PER_QUEUE (SLOTS_PER_QUEUE),
        .EVENT_COUNT     (EVENT_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .st          (st)
    );

endmodule
